FILE: rtl/core/seu_pkg.sv
// ----------------------------------------------------------------------------
// seu_pkg
// Shared types, result codes and the fixed-field layout of the stat entry
// unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package seu_pkg;

    localparam int FIXED_LEN   = 49;
    localparam int NUM_STRINGS = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    // result field ids
    localparam logic [3:0] FID_SIZE    = 4'd0;
    localparam logic [3:0] FID_STRBYTE = 4'd10;
    localparam logic [3:0] FID_STREND  = 4'd11;
    localparam logic [3:0] FID_END     = 4'd12;

    // parser phases after the fixed fields
    localparam logic [3:0] PH_LEN_LO = 4'd10;
    localparam logic [3:0] PH_LEN_HI = 4'd11;
    localparam logic [3:0] PH_BYTES  = 4'd12;
    localparam logic [3:0] PH_DONE   = 4'd13;

    // entry end status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_OVERRUN  = 3'd3;
    localparam logic [2:0] ST_TRAILING = 3'd4;

    // results caused by one input byte, in delivery order
    typedef struct packed {
        logic        has_main;
        logic [3:0]  main_fid;
        logic [63:0] main_value;
        logic [1:0]  main_sidx;
        logic        has_strend;
        logic [1:0]  strend_sidx;
        logic        has_end;
        logic [2:0]  end_status;
        logic [16:0] end_consumed;
    } seu_req_t;

    // byte offset just past fixed field fc
    function automatic logic [5:0] field_end(input logic [3:0] fc);
        logic [5:0] r;
        unique case (fc)
            4'd0:    r = 6'd2;
            4'd1:    r = 6'd4;
            4'd2:    r = 6'd8;
            4'd3:    r = 6'd9;
            4'd4:    r = 6'd13;
            4'd5:    r = 6'd21;
            4'd6:    r = 6'd25;
            4'd7:    r = 6'd29;
            4'd8:    r = 6'd33;
            4'd9:    r = 6'd41;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/seu_front.sv
// ----------------------------------------------------------------------------
// seu_front
// Byte parser: tracks the entry layout and turns each byte into a request
// holding the results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module seu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              copy_strings,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic              q_full,
    output logic                   q_push,
    output seu_pkg::seu_req_t      q_data
);
    import seu_pkg::*;

    logic [16:0] pos_reg, pos_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  fc_reg, fc_next;
    logic [2:0]  sc_reg, sc_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] decl_reg, decl_next;
    logic        trail_reg, trail_next;
    logic [16:0] send_reg, send_next;

    logic        accept;
    logic        do_finish;
    logic [5:0]  fstart;
    logic [5:0]  fend;
    logic [2:0]  boff;
    logic [63:0] acc_or;
    logic [15:0] rem_val;
    logic [17:0] nbuf;
    logic [17:0] expect_len;
    seu_req_t    req;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        fc_next    = fc_reg;
        sc_next    = sc_reg;
        rem_next   = rem_reg;
        decl_next  = decl_reg;
        trail_next = trail_reg;
        send_next  = send_reg;
        req        = '0;
        do_finish  = 1'b0;
        rem_val    = 16'd0;

        fstart = (fc_reg == FID_SIZE) ? 6'd0 : field_end(fc_reg - 4'd1);
        fend   = field_end(fc_reg);
        boff   = pos_reg[2:0] - fstart[2:0];
        acc_or = acc_reg | ({56'd0, in_byte} << {boff, 3'b000});
        nbuf   = {1'b0, pos_reg} + 18'd1;
        expect_len = {2'b00, decl_reg} + 18'd2;

        if (pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + 17'd1;
        end

        if (fc_reg < PH_LEN_LO)
        begin
            if (nbuf == {12'd0, fend})
            begin
                if (fc_reg == FID_SIZE)
                begin
                    decl_next = acc_or[15:0];
                end
                req.has_main   = 1'b1;
                req.main_fid   = fc_reg;
                req.main_value = acc_or;
                acc_next       = 64'd0;
                fc_next        = fc_reg + 4'd1;
            end
            else
            begin
                acc_next = acc_or;
            end
        end
        else if (fc_reg == PH_LEN_LO)
        begin
            acc_next = {56'd0, in_byte};
            fc_next  = PH_LEN_HI;
        end
        else if (fc_reg == PH_LEN_HI)
        begin
            rem_val  = {in_byte, acc_reg[7:0]};
            rem_next = rem_val;
            acc_next = 64'd0;
            if (rem_val == 16'd0)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                fc_next = PH_BYTES;
            end
        end
        else if (fc_reg == PH_BYTES)
        begin
            if (copy_strings)
            begin
                req.has_main   = 1'b1;
                req.main_fid   = FID_STRBYTE;
                req.main_value = {56'd0, in_byte};
                req.main_sidx  = sc_reg[1:0];
            end
            rem_next = rem_reg - 16'd1;
            if (rem_next == 16'd0)
            begin
                do_finish = 1'b1;
            end
        end
        else
        begin
            trail_next = 1'b1;
        end

        if (do_finish)
        begin
            if (copy_strings)
            begin
                req.has_strend  = 1'b1;
                req.strend_sidx = sc_reg[1:0];
            end
            sc_next = sc_reg + 3'd1;
            if (sc_next >= 3'(NUM_STRINGS))
            begin
                fc_next   = PH_DONE;
                send_next = pos_next;
            end
            else
            begin
                fc_next = PH_LEN_LO;
            end
        end

        if (in_last)
        begin
            // size check sees a declared size that completes on this byte
            expect_len = {2'b00, decl_next} + 18'd2;
            req.has_end = 1'b1;
            if (nbuf < 18'(FIXED_LEN))
            begin
                req.end_status = ST_SHORT;
            end
            else if (nbuf != expect_len)
            begin
                req.end_status = ST_MISMATCH;
            end
            else if (sc_next < 3'(NUM_STRINGS))
            begin
                req.end_status = ST_OVERRUN;
            end
            else if (trail_next)
            begin
                req.end_status = ST_TRAILING;
            end
            else
            begin
                req.end_status = ST_OK;
            end
            if (req.end_status == ST_OK || req.end_status == ST_TRAILING)
            begin
                req.end_consumed = send_next;
            end
            pos_next   = 17'd0;
            acc_next   = 64'd0;
            fc_next    = 4'd0;
            sc_next    = 3'd0;
            rem_next   = 16'd0;
            decl_next  = 16'd0;
            trail_next = 1'b0;
            send_next  = 17'd0;
        end
    end

    assign q_push = accept && (req.has_main || req.has_strend || req.has_end);
    assign q_data = req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            acc_reg   <= '0;
            fc_reg    <= '0;
            sc_reg    <= '0;
            rem_reg   <= '0;
            decl_reg  <= '0;
            trail_reg <= 1'b0;
            send_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            fc_reg    <= fc_next;
            sc_reg    <= sc_next;
            rem_reg   <= rem_next;
            decl_reg  <= decl_next;
            trail_reg <= trail_next;
            send_reg  <= send_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/seu_queue.sv
// ----------------------------------------------------------------------------
// seu_queue
// Short request queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module seu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire seu_pkg::seu_req_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output seu_pkg::seu_req_t      pop_data,
    output logic                   empty
);
    import seu_pkg::*;

    seu_req_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_reg, wr_next;
    logic [QUEUE_AW-1:0]   rd_reg, rd_next;
    logic [QUEUE_AW:0]     cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/seu_back.sv
// ----------------------------------------------------------------------------
// seu_back
// Result sequencer: holds one request and delivers its results in order,
// marking the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module seu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire seu_pkg::seu_req_t q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [3:0]             out_fid,
    output logic [63:0]            out_value,
    output logic [1:0]             out_sidx,
    output logic [2:0]             out_status,
    output logic [16:0]            out_consumed,
    output logic                   out_last
);
    import seu_pkg::*;

    seu_req_t   cur_reg;
    logic [2:0] pend_reg, pend_next;
    logic [2:0] pend_after;
    logic       done;

    assign out_valid  = (pend_reg != 3'b000);
    assign pend_after = pend_reg & (pend_reg - 3'b001);
    assign out_last   = (pend_after == 3'b000);
    assign done       = out_valid && out_ready && out_last;
    assign q_pop      = !q_empty && (!out_valid || done);

    always_comb
    begin
        out_fid      = FID_END;
        out_value    = 64'd0;
        out_sidx     = 2'd0;
        out_status   = ST_OK;
        out_consumed = 17'd0;
        priority if (pend_reg[0])
        begin
            out_fid   = cur_reg.main_fid;
            out_value = cur_reg.main_value;
            out_sidx  = cur_reg.main_sidx;
        end
        else if (pend_reg[1])
        begin
            out_fid  = FID_STREND;
            out_sidx = cur_reg.strend_sidx;
        end
        else
        begin
            out_status   = cur_reg.end_status;
            out_consumed = cur_reg.end_consumed;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (out_valid && out_ready)
        begin
            pend_next = pend_after;
        end
        if (q_pop)
        begin
            pend_next = {q_data.has_end, q_data.has_strend, q_data.has_main};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'b000;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stat_entry_unpacker.sv
// ----------------------------------------------------------------------------
// stat_entry_unpacker
// Streaming unpacker for one packed directory-stat entry, one byte per
// request, emitting fixed fields, string bytes, string ends and an entry end.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] data_byte, tlast last_byte
//  m_*      out  m_tvalid/m_tready  tuser field_id, tdata value..consumed,
//                                   tlast run_last
//  cfg_*    in   cfg_valid/cfg_ready cfg_data copy_strings
//
//  the parser takes one byte per cycle; each byte that causes results becomes
//  one request in a four-entry queue, and the sequencer delivers one result
//  per cycle; a byte causes 0 to 3 results. the first result of a byte leaves
//  after its request passes through a queue slot and the sequencer register.
//  input stalls only when the queue is full; output stalls back up into it.
//  reset clears the parser, queue and sequencer; copy_strings resets to 1.
//  cfg_ready is always high.
//
`default_nettype none

module stat_entry_unpacker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [63:0] value, [65:64] string_index,
                                        // [68:66] status, [85:69] consumed
    output logic [3:0]       m_tuser,   // [3:0] field_id
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import seu_pkg::*;

    logic        copy_reg;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    seu_req_t    push_req;
    seu_req_t    pop_req;
    logic [63:0] out_value;
    logic [1:0]  out_sidx;
    logic [2:0]  out_status;
    logic [16:0] out_consumed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            copy_reg <= cfg_data;
        end
    end

    seu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .copy_strings (copy_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_req)
    );

    seu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_req),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_req),
        .empty     (q_empty)
    );

    seu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (pop_req),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_fid      (m_tuser),
        .out_value    (out_value),
        .out_sidx     (out_sidx),
        .out_status   (out_status),
        .out_consumed (out_consumed),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, out_consumed, out_status, out_sidx, out_value};

endmodule

`default_nettype wire

FILE: rtl/core/seu_checker.sv
// ----------------------------------------------------------------------------
// seu_checker
// Port-level checks of the stat entry unpacker result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module seu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        m_tlast
);
    import seu_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // entry end is always the final result of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == FID_END |-> m_tlast)
        else $error("entry end without tlast");

    // status and consumed only carry data on entry end
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != FID_END |-> m_tdata[85:66] == 20'd0)
        else $error("status or consumed set outside entry end");

    // a string end is the last result of its byte unless an entry end follows
    a_strend_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == FID_STREND && !m_tlast
        |=> m_tvalid && m_tuser == FID_END)
        else $error("string end followed by wrong result");

endmodule

bind stat_entry_unpacker seu_checker u_seu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/stat_entry_unpacker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stat_entry_unpacker_test
// Streams stat entries into the unpacker a byte at a time and checks every
// emitted field, string byte, string end and entry end against a software
// unpacker kept in the testbench. A short table of directed bytes comes
// first, then random entries: well-formed, trailing bytes, size mismatch,
// string overrun, short and noise buffers. Both sides stall at random, and
// copy_strings is switched between entries.
// ----------------------------------------------------------------------------

module stat_entry_unpacker_test;

    import seu_pkg::*;

    typedef struct packed {
        logic [3:0]  fid;
        logic [63:0] value;
        logic [1:0]  sidx;
        logic [2:0]  status;
        logic [16:0] consumed;
        logic        run_last;
    } stat_rec_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic [2:0] status;
    } dir_row_t;

    typedef enum int {
        EK_WELL,
        EK_TRAIL,
        EK_MISMATCH,
        EK_OVERRUN,
        EK_SHORT,
        EK_NOISE
    } entry_kind_e;

    localparam int DRAIN_CYCLES = 32;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    // travels with each request: entry end typed in by the table
    logic        row_typed  = 1'b0;
    logic [2:0]  row_status = ST_OK;

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int bad_fields   = 0;
    int forced_kind  = EK_WELL;

    stat_rec_t  pending_fields [$];
    logic [7:0] entry_buf [$];
    dir_row_t   dir_table [25];

    // offsets just past each fixed field
    int field_stop [10] = '{2, 4, 8, 9, 13, 21, 25, 29, 33, 41};

    // software unpacker state
    logic        p_copy = 1'b1;
    int          p_pos = 0;
    logic [63:0] p_acc = '0;
    logic [3:0]  p_phase = '0;
    int          p_str = 0;
    logic [15:0] p_remain = '0;
    int          p_size = 0;
    logic        p_trail = 1'b0;
    int          p_strend = 0;

    stat_entry_unpacker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_field(input logic [3:0] fid, input logic [63:0] v,
                                       input logic [1:0] si, input logic [2:0] st,
                                       input logic [16:0] cons);
        stat_rec_t r;
        r.fid      = fid;
        r.value    = v;
        r.sidx     = si;
        r.status   = st;
        r.consumed = cons;
        r.run_last = 1'b0;
        pending_fields.push_back(r);
    endfunction

    function automatic void close_string();
        if (p_copy)
            push_field(FID_STREND, 64'd0, p_str[1:0], ST_OK, 17'd0);
        p_str++;
        if (p_str >= NUM_STRINGS)
        begin
            p_phase  = PH_DONE;
            p_strend = p_pos;
        end
        else
            p_phase = PH_LEN_LO;
    endfunction

    function automatic void unpack_byte(input logic [7:0] b, input logic fin);
        int          pos;
        int          start;
        int          nbuf;
        int          first;
        logic [2:0]  st;
        logic [16:0] cons;
        stat_rec_t   tail;
        first = pending_fields.size();
        pos   = p_pos;
        if (p_pos < int'(POS_MAX))
            p_pos++;

        if (p_phase < PH_LEN_LO)
        begin
            start = (p_phase == 4'd0) ? 0 : field_stop[p_phase - 1];
            p_acc |= 64'(b) << (((pos - start) & 7) * 8);
            if (pos + 1 == field_stop[p_phase])
            begin
                if (p_phase == FID_SIZE)
                    p_size = int'(p_acc[15:0]);
                push_field(p_phase, p_acc, 2'd0, ST_OK, 17'd0);
                p_acc   = '0;
                p_phase = p_phase + 4'd1;
            end
        end
        else if (p_phase == PH_LEN_LO)
        begin
            p_acc   = 64'(b);
            p_phase = PH_LEN_HI;
        end
        else if (p_phase == PH_LEN_HI)
        begin
            p_remain = {b, p_acc[7:0]};
            p_acc    = '0;
            if (p_remain == 16'd0)
                close_string();
            else
                p_phase = PH_BYTES;
        end
        else if (p_phase == PH_BYTES)
        begin
            if (p_copy)
                push_field(FID_STRBYTE, 64'(b), p_str[1:0], ST_OK, 17'd0);
            p_remain = p_remain - 16'd1;
            if (p_remain == 16'd0)
                close_string();
        end
        else
            p_trail = 1'b1;

        if (fin)
        begin
            nbuf = pos + 1;
            cons = '0;
            if (nbuf < FIXED_LEN)
                st = ST_SHORT;
            else if (nbuf != 2 + p_size)
                st = ST_MISMATCH;
            else if (p_str < NUM_STRINGS)
                st = ST_OVERRUN;
            else if (p_trail)
                st = ST_TRAILING;
            else
                st = ST_OK;
            if (st == ST_OK || st == ST_TRAILING)
                cons = 17'(p_strend);
            push_field(FID_END, 64'd0, 2'd0, st, cons);
            p_pos    = 0;
            p_acc    = '0;
            p_phase  = '0;
            p_str    = 0;
            p_remain = '0;
            p_size   = 0;
            p_trail  = 1'b0;
            p_strend = 0;
        end

        if (pending_fields.size() > first)
        begin
            tail = pending_fields[$];
            tail.run_last = 1'b1;
            pending_fields[$] = tail;
        end
    endfunction

    // prediction on accepted requests, then comparison of delivered results
    always @(posedge clk)
    begin
        stat_rec_t want;
        stat_rec_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                p_copy = cfg_data;

            if (s_tvalid && s_tready)
            begin
                unpack_byte(s_tdata, s_tlast);
                if (row_typed)
                begin
                    void'(pending_fields.pop_back());
                    want.fid      = FID_END;
                    want.value    = 64'd0;
                    want.sidx     = 2'd0;
                    want.status   = row_status;
                    want.consumed = 17'd0;
                    want.run_last = 1'b1;
                    pending_fields.push_back(want);
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.fid      = m_tuser;
                got.value    = m_tdata[63:0];
                got.sidx     = m_tdata[65:64];
                got.status   = m_tdata[68:66];
                got.consumed = m_tdata[85:69];
                got.run_last = m_tlast;
                if (pending_fields.size() == 0)
                begin
                    bad_fields++;
                    if (bad_fields <= 10)
                        $display("%0t: unexpected result fid %0d value %h", $realtime,
                                 got.fid, got.value);
                end
                else
                begin
                    want = pending_fields.pop_front();
                    if (got !== want)
                    begin
                        bad_fields++;
                        if (bad_fields <= 10)
                            $display({"%0t: mismatch exp/got fid %0d/%0d value %h/%h ",
                                      "idx %0d/%0d st %0d/%0d cons %0d/%0d last %0d/%0d"},
                                     $realtime, want.fid, got.fid, want.value, got.value,
                                     want.sidx, got.sidx, want.status, got.status,
                                     want.consumed, got.consumed, want.run_last,
                                     got.run_last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [2:0] st);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tlast    <= fin;
        row_typed  <= typed;
        row_status <= st;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_copy_strings(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_entry(input int kind);
        int          lens [4];
        int          total;
        int          cut;
        int          n;
        logic [15:0] dsize;
        entry_buf.delete();
        if (kind == EK_SHORT || kind == EK_NOISE)
        begin
            n = (kind == EK_SHORT) ? $urandom_range(48, 1) : $urandom_range(90, 49);
            repeat (n) entry_buf.push_back(8'($urandom));
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (kind == EK_OVERRUN)
                    lens[k] = $urandom_range(6, 1);
                else if ($urandom_range(2) == 0)
                    lens[k] = 0;
                else
                    lens[k] = $urandom_range(4, 1);
            end

            repeat (41) entry_buf.push_back(8'($urandom));
            for (int k = 0; k < 4; k++)
            begin
                entry_buf.push_back(8'(lens[k]));
                entry_buf.push_back(8'(lens[k] >> 8));
                repeat (lens[k]) entry_buf.push_back(8'($urandom));
            end
            if (kind == EK_TRAIL)
                repeat ($urandom_range(3, 1)) entry_buf.push_back(8'($urandom));

            total = entry_buf.size();
            dsize = 16'(total - 2);
            if (kind == EK_MISMATCH)
                dsize = ($urandom_range(1) == 0) ? dsize + 16'($urandom_range(65535, 1))
                                                 : dsize - 16'd1;
            else if (kind == EK_OVERRUN)
            begin
                cut = $urandom_range(total - 1, FIXED_LEN);
                while (entry_buf.size() > cut)
                    void'(entry_buf.pop_back());
                dsize = 16'(cut - 2);
            end
            entry_buf[0] = dsize[7:0];
            entry_buf[1] = dsize[15:8];
        end
    endtask

    task automatic send_entry();
        for (int i = 0; i < entry_buf.size(); i++)
            send_byte(entry_buf[i], i == entry_buf.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic run_random(input int quota);
        int sent;
        int r;
        int kind;
        sent = 0;
        while (sent < quota)
        begin
            // every kind once before the mix is random
            if (forced_kind <= EK_NOISE)
            begin
                kind = forced_kind;
                forced_kind++;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 40)
                    kind = EK_WELL;
                else if (r < 55)
                    kind = EK_TRAIL;
                else if (r < 70)
                    kind = EK_MISMATCH;
                else if (r < 80)
                    kind = EK_OVERRUN;
                else if (r < 90)
                    kind = EK_SHORT;
                else
                    kind = EK_NOISE;
            end
            build_entry(kind);
            send_entry();
            sent += entry_buf.size();
        end
    endtask

    initial
    begin
        // single byte, all-ones fixed fields cut short, all-ones last byte
        dir_table[0] = '{8'h00, 1'b1, 1'b1, ST_SHORT};
        for (int i = 1; i <= 22; i++)
            dir_table[i] = '{8'hFF, 1'b0, 1'b0, ST_OK};
        dir_table[23] = '{8'h00, 1'b1, 1'b1, ST_SHORT};
        dir_table[24] = '{8'hFF, 1'b1, 1'b1, ST_SHORT};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gap_pct   = 21;
        rx_stall_pct = 61;
        for (int i = 0; i < 25; i++)
            send_byte(dir_table[i].data, dir_table[i].fin, dir_table[i].typed,
                      dir_table[i].status);
        run_random(110);
        drain();
        write_copy_strings(1'b0);

        tx_gap_pct   = 61;
        rx_stall_pct = 21;
        run_random(100);
        drain();
        write_copy_strings(1'b1);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_random(80);
        drain();

        if (bad_fields == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
